// ----- rtl/core/table_interp_angle_2d_defines.svh -----
// ----------------------------------------------------------------------------
// Table interpolation assertion macros
// Shared concurrent assertion forms for the angle interpolator checks.
// ----------------------------------------------------------------------------
`ifndef TABLE_INTERP_ANGLE_2D_DEFINES_SVH
`define TABLE_INTERP_ANGLE_2D_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TIA2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TIA2D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tia2d_pkg.sv -----
// ----------------------------------------------------------------------------
// Table interpolation package
// Types, field widths and codes of the angle interpolator.
// ----------------------------------------------------------------------------
package tia2d_pkg;

   localparam int ALT_W   = 24;
   localparam int SPD_W   = 16;
   localparam int ANG_W   = 14;
   localparam int IDX_W   = 8;
   localparam int FRAC_W  = 16;
   localparam int WGT_W   = 17;
   localparam int MS_W    = 36;
   localparam int MA_W    = 32;
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = 50;
   localparam int DIV_W   = 36;
   localparam int Q_BITS  = 16;
   localparam int CNT_W   = 5;

   localparam logic [WGT_W-1:0] WGT_ONE       = 17'h10000;
   localparam logic [ANG_W-1:0] ANG_MAX       = 14'h3FFF;
   localparam logic [ANG_W-1:0] MAX_ANGLE_RST = 14'd13440;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] RS_INTERP = 2'd0;
   localparam logic [1:0] RS_BELOW  = 2'd1;
   localparam logic [1:0] RS_ABOVE  = 2'd2;

   typedef struct packed {
      logic signed [ALT_W-1:0] alt;
      logic signed [SPD_W-1:0] spd;
      logic        [ANG_W-1:0] ang;
   } row_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_SCAN,
      ST_ALT_LO,
      ST_DIV_PHI,
      ST_BL_RDL,
      ST_BL_RDH,
      ST_BL_MS,
      ST_BL_MA,
      ST_BL_EVAL,
      ST_TH_CHK,
      ST_DIV_TH,
      ST_ACC,
      ST_ACC2,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/tia2d_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying row writes and angle queries.
// ----------------------------------------------------------------------------
interface tia2d_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic        [tia2d_pkg::IDX_W-1:0]     row_index;
   logic signed [tia2d_pkg::ALT_W-1:0]     row_altitude;
   logic signed [tia2d_pkg::SPD_W-1:0]     row_speed;
   logic        [tia2d_pkg::ANG_W-1:0]     row_angle;
   logic signed [tia2d_pkg::ALT_W-1:0]     query_altitude;
   logic signed [tia2d_pkg::SPD_W-1:0]     query_speed;

   modport source (
      output valid, func, row_index, row_altitude, row_speed, row_angle,
             query_altitude, query_speed,
      input  ready
   );
   modport sink (
      input  valid, func, row_index, row_altitude, row_speed, row_angle,
             query_altitude, query_speed,
      output ready
   );
endinterface

// ----- rtl/core/tia2d_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the interpolated angle and range status.
// ----------------------------------------------------------------------------
interface tia2d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tia2d_pkg::ANG_W-1:0]   opening_angle;
   logic [1:0]                    range_status;

   modport source (output valid, opening_angle, range_status, input ready);
   modport sink   (input valid, opening_angle, range_status, output ready);
endinterface

// ----- rtl/core/table_interp_angle_2d.sv -----
// ----------------------------------------------------------------------------
// Table interpolation of opening angle over altitude and speed
// Row table in one synchronous memory, walked by a sequencer with a shared
// multiplier and a radix-2 divider.
//
//   channel  dir  handshake       contents
//   req_bus  in   valid/ready     func, row write fields, query point
//   rsp_bus  out  valid/ready     opening_angle, range_status
//   csr_*    in   write enable    max_opening_angle
//
// Each division yields Q = 16 quotient bits from the serial divider, and the
// table has one read port. Out-of-grid queries finish early.
// Reset is synchronous and clears control only; table rows hold garbage
// until written. A finished response waits in the output register while
// the next request is taken.
// ----------------------------------------------------------------------------
module table_interp_angle_2d #(
   parameter int TABLE_ROWS        = 256,
   parameter int ROWS_PER_ALTITUDE = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   tia2d_req_if.sink                        req_bus,
   tia2d_rsp_if.source                      rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [tia2d_pkg::ANG_W-1:0]      csr_wr_data
);

   localparam int NUM_BLOCKS = TABLE_ROWS / ROWS_PER_ALTITUDE;
   localparam int LAST_BLOCK = (NUM_BLOCKS > 0) ? NUM_BLOCKS - 1 : 0;
   localparam int AW         = $clog2(TABLE_ROWS);
   localparam int EW         = $clog2(TABLE_ROWS + ROWS_PER_ALTITUDE + 1);
   localparam int JW         = $clog2(ROWS_PER_ALTITUDE);

   localparam logic [EW-1:0] ROW_STEP  = EW'(ROWS_PER_ALTITUDE);
   localparam logic [EW-1:0] LAST_ROW  = EW'(LAST_BLOCK * ROWS_PER_ALTITUDE);
   localparam logic [EW-1:0] TOP_ROW   = EW'(TABLE_ROWS - 1);
   localparam logic [EW-1:0] ROW_LIMIT = EW'(TABLE_ROWS);
   localparam logic [JW-1:0] J_LAST    = JW'(ROWS_PER_ALTITUDE - 1);

   tia2d_pkg::state_type state_ff, state_in;

   tia2d_pkg::row_type mem [TABLE_ROWS];
   tia2d_pkg::row_type rd_data_ff;
   logic               rd_ok_ff;
   logic [EW-1:0]      rd_addr;
   logic               mem_we;
   logic [31:0]        wr_idx;

   logic signed [tia2d_pkg::ALT_W-1:0] q_alt_ff, q_alt_in;
   logic signed [tia2d_pkg::SPD_W-1:0] q_spd_ff, q_spd_in;
   logic [EW-1:0] scan_row_ff, scan_row_in;
   logic [EW-1:0] hi_row_ff, hi_row_in;
   logic [EW-1:0] lo_row_ff, lo_row_in;
   logic signed [tia2d_pkg::ALT_W-1:0] alt_hi_ff, alt_hi_in;
   logic [JW-1:0] j_ff, j_in;
   logic [tia2d_pkg::WGT_W-1:0] phi_ff, phi_in, theta_ff, theta_in;
   logic signed [tia2d_pkg::SPD_W-1:0] sl_ff, sl_in;
   logic [tia2d_pkg::ANG_W-1:0] gl_ff, gl_in;
   logic signed [tia2d_pkg::ANG_W:0] gdiff_ff, gdiff_in;
   logic signed [tia2d_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic signed [tia2d_pkg::MS_W-1:0] ms_cur_ff, ms_cur_in;
   logic signed [tia2d_pkg::MS_W-1:0] ms_prev_ff, ms_prev_in;
   logic signed [tia2d_pkg::MS_W-1:0] ms_lo_ff, ms_lo_in, ms_hi_ff, ms_hi_in;
   logic signed [tia2d_pkg::MA_W-1:0] ma_prev_ff, ma_prev_in;
   logic signed [tia2d_pkg::MA_W-1:0] ma_lo_ff, ma_lo_in, ma_hi_ff, ma_hi_in;
   logic found_ff, found_in, kzero_ff, kzero_in;
   logic [tia2d_pkg::DIV_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [tia2d_pkg::Q_BITS-1:0] quo_ff, quo_in;
   logic [tia2d_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [tia2d_pkg::ANG_W-1:0] res_angle_ff, res_angle_in;
   logic [1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tia2d_pkg::ANG_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [tia2d_pkg::ANG_W-1:0] max_angle_ff, max_angle_in;

   logic req_acc;
   logic signed [tia2d_pkg::ALT_W-1:0] row_alt;
   logic signed [tia2d_pkg::SPD_W-1:0] row_spd;
   logic [tia2d_pkg::ANG_W-1:0] row_ang;
   logic signed [tia2d_pkg::ALT_W:0] alt_num, alt_den;
   logic phi_zero, phi_full, scan_hit;
   logic signed [tia2d_pkg::SPD_W:0] spd_diff;
   logic signed [tia2d_pkg::MA_W-1:0] ma_cur;
   logic signed [tia2d_pkg::MS_W-1:0] vq;
   logic ms_below, ms_above, j_last, found_now, kzero_now;
   logic signed [tia2d_pkg::MS_W:0] th_num, th_den;
   logic th_zero, th_full;
   logic [tia2d_pkg::DIV_W:0] div_r2;
   logic div_ge, div_last;
   logic [tia2d_pkg::Q_BITS-1:0] div_quo;
   logic signed [tia2d_pkg::MUL_A_W-1:0] mul_a;
   logic signed [tia2d_pkg::MUL_B_W-1:0] mul_b;
   logic signed [tia2d_pkg::PROD_W-1:0] acc, acc_pos, acc_rnd;
   logic [tia2d_pkg::PROD_W-33:0] ang_full;
   logic [tia2d_pkg::ANG_W-1:0] ang_sat;
   logic out_free;

   // shared conditions
   always_comb begin
      req_acc  = req_bus.valid && req_bus.ready;
      row_alt  = rd_ok_ff ? rd_data_ff.alt : '0;
      row_spd  = rd_ok_ff ? rd_data_ff.spd : '0;
      row_ang  = rd_ok_ff ? rd_data_ff.ang : '0;
      scan_hit = (row_alt >= q_alt_ff) || (scan_row_ff == LAST_ROW);
      alt_num  = (tia2d_pkg::ALT_W+1)'(q_alt_ff) - (tia2d_pkg::ALT_W+1)'(row_alt);
      alt_den  = (tia2d_pkg::ALT_W+1)'(alt_hi_ff) - (tia2d_pkg::ALT_W+1)'(row_alt);
      phi_zero = (hi_row_ff == '0) || (alt_num <= 0) || (alt_den <= 0);
      phi_full = alt_num >= alt_den;
      spd_diff = (tia2d_pkg::SPD_W+1)'(row_spd) - (tia2d_pkg::SPD_W+1)'(sl_ff);
      ma_cur   = $signed(tia2d_pkg::MA_W'({gl_ff, 16'h0}))
               + tia2d_pkg::MA_W'(mul_ff);
      vq       = $signed({{4{q_spd_ff[tia2d_pkg::SPD_W-1]}}, q_spd_ff, 16'h0});
      ms_below = vq < ms_cur_ff;
      ms_above = vq > ms_cur_ff;
      j_last   = j_ff == J_LAST;
      found_now = !found_ff && (ms_cur_ff >= vq);
      kzero_now = found_now ? (j_ff == '0) : kzero_ff;
      th_num   = (tia2d_pkg::MS_W+1)'(vq) - (tia2d_pkg::MS_W+1)'(ms_lo_ff);
      th_den   = (tia2d_pkg::MS_W+1)'(ms_hi_ff) - (tia2d_pkg::MS_W+1)'(ms_lo_ff);
      th_zero  = (th_num <= 0) || (th_den <= 0);
      th_full  = th_num >= th_den;
      div_r2   = {rem_ff, 1'b0};
      div_ge   = div_r2 >= {1'b0, den_ff};
      div_last = cnt_ff == tia2d_pkg::CNT_W'(tia2d_pkg::Q_BITS - 1);
      div_quo  = {quo_ff[tia2d_pkg::Q_BITS-2:0], div_ge};
      acc      = (tia2d_pkg::PROD_W'(ma_lo_ff) <<< tia2d_pkg::FRAC_W) + mul_ff;
      acc_pos  = (acc < 0) ? '0 : acc;
      acc_rnd  = acc_pos + tia2d_pkg::PROD_W'(64'h8000_0000);
      ang_full = acc_rnd[tia2d_pkg::PROD_W-1:32];
      ang_sat  = (|ang_full[tia2d_pkg::PROD_W-33:tia2d_pkg::ANG_W]) ?
                 tia2d_pkg::ANG_MAX : ang_full[tia2d_pkg::ANG_W-1:0];
      out_free = !rsp_valid_ff || rsp_bus.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tia2d_pkg::ST_IDLE: begin
            if (req_acc && req_bus.func == tia2d_pkg::FUNC_QUERY) begin
               state_in = tia2d_pkg::ST_RD_FIRST;
            end
         end
         tia2d_pkg::ST_RD_FIRST:  state_in = tia2d_pkg::ST_CHK_FIRST;
         tia2d_pkg::ST_CHK_FIRST: begin
            state_in = (q_alt_ff < row_alt) ? tia2d_pkg::ST_DONE : tia2d_pkg::ST_CHK_LAST;
         end
         tia2d_pkg::ST_CHK_LAST: begin
            state_in = (q_alt_ff > row_alt) ? tia2d_pkg::ST_DONE : tia2d_pkg::ST_SCAN;
         end
         tia2d_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = tia2d_pkg::ST_ALT_LO;
            end
         end
         tia2d_pkg::ST_ALT_LO: begin
            state_in = (phi_zero || phi_full) ? tia2d_pkg::ST_BL_RDL : tia2d_pkg::ST_DIV_PHI;
         end
         tia2d_pkg::ST_DIV_PHI: begin
            if (div_last) begin
               state_in = tia2d_pkg::ST_BL_RDL;
            end
         end
         tia2d_pkg::ST_BL_RDL: state_in = tia2d_pkg::ST_BL_RDH;
         tia2d_pkg::ST_BL_RDH: state_in = tia2d_pkg::ST_BL_MS;
         tia2d_pkg::ST_BL_MS:  state_in = tia2d_pkg::ST_BL_MA;
         tia2d_pkg::ST_BL_MA:  state_in = tia2d_pkg::ST_BL_EVAL;
         tia2d_pkg::ST_BL_EVAL: begin
            if (j_ff == '0 && ms_below) begin
               state_in = tia2d_pkg::ST_DONE;
            end else if (!j_last) begin
               state_in = tia2d_pkg::ST_BL_RDL;
            end else if (ms_above) begin
               state_in = tia2d_pkg::ST_DONE;
            end else if (kzero_now) begin
               state_in = tia2d_pkg::ST_ACC;
            end else begin
               state_in = tia2d_pkg::ST_TH_CHK;
            end
         end
         tia2d_pkg::ST_TH_CHK: begin
            state_in = (th_zero || th_full) ? tia2d_pkg::ST_ACC : tia2d_pkg::ST_DIV_TH;
         end
         tia2d_pkg::ST_DIV_TH: begin
            if (div_last) begin
               state_in = tia2d_pkg::ST_ACC;
            end
         end
         tia2d_pkg::ST_ACC:  state_in = tia2d_pkg::ST_ACC2;
         tia2d_pkg::ST_ACC2: state_in = tia2d_pkg::ST_DONE;
         tia2d_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tia2d_pkg::ST_IDLE;
            end
         end
         default: state_in = tia2d_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_alt_in      = q_alt_ff;
      q_spd_in      = q_spd_ff;
      scan_row_in   = scan_row_ff;
      hi_row_in     = hi_row_ff;
      lo_row_in     = lo_row_ff;
      alt_hi_in     = alt_hi_ff;
      j_in          = j_ff;
      phi_in        = phi_ff;
      theta_in      = theta_ff;
      sl_in         = sl_ff;
      gl_in         = gl_ff;
      gdiff_in      = gdiff_ff;
      ms_cur_in     = ms_cur_ff;
      ms_prev_in    = ms_prev_ff;
      ma_prev_in    = ma_prev_ff;
      ms_lo_in      = ms_lo_ff;
      ms_hi_in      = ms_hi_ff;
      ma_lo_in      = ma_lo_ff;
      ma_hi_in      = ma_hi_ff;
      found_in      = found_ff;
      kzero_in      = kzero_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      res_angle_in  = res_angle_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      mul_a         = '0;
      mul_b         = $signed({1'b0, phi_ff});
      req_bus.ready = 1'b0;

      unique case (state_ff)
         tia2d_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            q_alt_in = req_bus.query_altitude;
            q_spd_in = req_bus.query_speed;
            j_in     = '0;
            found_in = 1'b0;
            kzero_in = 1'b0;
            mem_we   = req_acc && req_bus.func == tia2d_pkg::FUNC_WRITE
                       && wr_idx < 32'(TABLE_ROWS);
         end
         tia2d_pkg::ST_RD_FIRST: rd_addr = '0;
         tia2d_pkg::ST_CHK_FIRST: begin
            rd_addr       = TOP_ROW;
            res_angle_in  = '0;
            res_status_in = tia2d_pkg::RS_BELOW;
         end
         tia2d_pkg::ST_CHK_LAST: begin
            rd_addr       = '0;
            scan_row_in   = '0;
            res_angle_in  = max_angle_ff;
            res_status_in = tia2d_pkg::RS_ABOVE;
         end
         tia2d_pkg::ST_SCAN: begin
            if (scan_hit) begin
               hi_row_in = scan_row_ff;
               lo_row_in = (scan_row_ff != '0) ? scan_row_ff - ROW_STEP : '0;
               alt_hi_in = row_alt;
               rd_addr   = lo_row_in;
            end else begin
               scan_row_in = scan_row_ff + ROW_STEP;
               rd_addr     = scan_row_in;
            end
         end
         tia2d_pkg::ST_ALT_LO: begin
            phi_in = phi_zero ? '0 : tia2d_pkg::WGT_ONE;
            rem_in = tia2d_pkg::DIV_W'($unsigned(alt_num));
            den_in = tia2d_pkg::DIV_W'($unsigned(alt_den));
            cnt_in = '0;
            quo_in = '0;
         end
         tia2d_pkg::ST_DIV_PHI, tia2d_pkg::ST_DIV_TH: begin
            rem_in = div_ge ? tia2d_pkg::DIV_W'(div_r2 - {1'b0, den_ff})
                            : tia2d_pkg::DIV_W'(div_r2);
            quo_in = div_quo;
            cnt_in = cnt_ff + 1'b1;
            if (div_last && state_ff == tia2d_pkg::ST_DIV_PHI) begin
               phi_in = {1'b0, div_quo};
            end
            if (div_last && state_ff == tia2d_pkg::ST_DIV_TH) begin
               theta_in = {1'b0, div_quo};
            end
         end
         tia2d_pkg::ST_BL_RDL: rd_addr = lo_row_ff + EW'(j_ff);
         tia2d_pkg::ST_BL_RDH: begin
            rd_addr = hi_row_ff + EW'(j_ff);
            sl_in   = row_spd;
            gl_in   = row_ang;
         end
         tia2d_pkg::ST_BL_MS: begin
            mul_a    = tia2d_pkg::MUL_A_W'(spd_diff);
            gdiff_in = $signed({1'b0, row_ang}) - $signed({1'b0, gl_ff});
         end
         tia2d_pkg::ST_BL_MA: begin
            mul_a     = tia2d_pkg::MUL_A_W'(gdiff_ff);
            ms_cur_in = $signed({{4{sl_ff[tia2d_pkg::SPD_W-1]}}, sl_ff, 16'h0})
                      + tia2d_pkg::MS_W'(mul_ff);
         end
         tia2d_pkg::ST_BL_EVAL: begin
            ms_prev_in = ms_cur_ff;
            ma_prev_in = ma_cur;
            if (found_now) begin
               found_in = 1'b1;
               kzero_in = j_ff == '0;
               ms_lo_in = (j_ff == '0) ? ms_cur_ff : ms_prev_ff;
               ma_lo_in = (j_ff == '0) ? ma_cur : ma_prev_ff;
               ms_hi_in = ms_cur_ff;
               ma_hi_in = ma_cur;
            end
            j_in     = j_ff + 1'b1;
            theta_in = '0;
            if (j_ff == '0 && ms_below) begin
               res_angle_in  = '0;
               res_status_in = tia2d_pkg::RS_BELOW;
            end else if (j_last && ms_above) begin
               res_angle_in  = max_angle_ff;
               res_status_in = tia2d_pkg::RS_ABOVE;
            end
         end
         tia2d_pkg::ST_TH_CHK: begin
            theta_in = th_zero ? '0 : tia2d_pkg::WGT_ONE;
            rem_in   = tia2d_pkg::DIV_W'($unsigned(th_num));
            den_in   = tia2d_pkg::DIV_W'($unsigned(th_den));
            cnt_in   = '0;
            quo_in   = '0;
         end
         tia2d_pkg::ST_ACC: begin
            mul_a = ma_hi_ff - ma_lo_ff;
            mul_b = $signed({1'b0, theta_ff});
         end
         tia2d_pkg::ST_ACC2: begin
            res_angle_in  = ang_sat;
            res_status_in = tia2d_pkg::RS_INTERP;
         end
         tia2d_pkg::ST_DONE: ;
         default: ;
      endcase

      mul_in = tia2d_pkg::PROD_W'(mul_a) * tia2d_pkg::PROD_W'(mul_b);
   end

   always_comb begin
      wr_idx        = 32'(req_bus.row_index);
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_angle_in  = rsp_angle_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == tia2d_pkg::ST_DONE && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_angle_in  = res_angle_ff;
         rsp_status_in = res_status_ff;
      end
      max_angle_in = csr_wr_en ? csr_wr_data : max_angle_ff;
      rsp_bus.valid         = rsp_valid_ff;
      rsp_bus.opening_angle = rsp_angle_ff;
      rsp_bus.range_status  = rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx[AW-1:0]] <= '{alt: req_bus.row_altitude, spd: req_bus.row_speed,
                                  ang: req_bus.row_angle};
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
      rd_ok_ff   <= rd_addr < ROW_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tia2d_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_angle_ff <= tia2d_pkg::MAX_ANGLE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_angle_ff <= max_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      q_alt_ff      <= q_alt_in;
      q_spd_ff      <= q_spd_in;
      scan_row_ff   <= scan_row_in;
      hi_row_ff     <= hi_row_in;
      lo_row_ff     <= lo_row_in;
      alt_hi_ff     <= alt_hi_in;
      j_ff          <= j_in;
      phi_ff        <= phi_in;
      theta_ff      <= theta_in;
      sl_ff         <= sl_in;
      gl_ff         <= gl_in;
      gdiff_ff      <= gdiff_in;
      mul_ff        <= mul_in;
      ms_cur_ff     <= ms_cur_in;
      ms_prev_ff    <= ms_prev_in;
      ma_prev_ff    <= ma_prev_in;
      ms_lo_ff      <= ms_lo_in;
      ms_hi_ff      <= ms_hi_in;
      ma_lo_ff      <= ma_lo_in;
      ma_hi_ff      <= ma_hi_in;
      found_ff      <= found_in;
      kzero_ff      <= kzero_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      res_angle_ff  <= res_angle_in;
      res_status_ff <= res_status_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- rtl/core/tia2d_checker.sv -----
// ----------------------------------------------------------------------------
// Table interpolation port checker
// Response channel checks seen from the top level's ports.
// ----------------------------------------------------------------------------
`include "table_interp_angle_2d_defines.svh"

module tia2d_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tia2d_pkg::ANG_W-1:0]      rsp_angle,
   input logic [1:0]                       rsp_status
);

   `TIA2D_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_angle) && $stable(rsp_status), "response dropped or changed while stalled")
   `TIA2D_ASSERT_IMP(a_status_legal, clock, reset, rsp_valid, rsp_status == tia2d_pkg::RS_INTERP || rsp_status == tia2d_pkg::RS_BELOW || rsp_status == tia2d_pkg::RS_ABOVE, "illegal range status")
   `TIA2D_ASSERT_IMP(a_below_zero, clock, reset, rsp_valid && rsp_status == tia2d_pkg::RS_BELOW, rsp_angle == '0, "below-grid response with nonzero angle")

endmodule

bind table_interp_angle_2d tia2d_checker u_tia2d_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_angle  (rsp_bus.opening_angle),
   .rsp_status (rsp_bus.range_status)
);
